### rtl/fms_pkg.sv
// Shared types, state codes and register indexes for the enclosure fan mode sequencer.
package fms_pkg;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RECIRC = 3'd1;
    localparam logic [2:0] ST_HEAT   = 3'd2;
    localparam logic [2:0] ST_COOL   = 3'd3;
    localparam logic [2:0] ST_MANUAL = 3'd4;

    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_HEAT   = 2'd1;
    localparam logic [1:0] MODE_COOL   = 2'd2;
    localparam logic [1:0] MODE_MANUAL = 2'd3;

    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_RECIRC_TEMP = 3'd1;
    localparam logic [2:0] CFG_HOT_TEMP    = 3'd2;
    localparam logic [2:0] CFG_MINUTES     = 3'd3;
    localparam logic [2:0] CFG_FAN_PRESENT = 3'd4;
    localparam logic [2:0] CFG_HOT_SPEEDS  = 3'd5;
    localparam logic [2:0] CFG_COLD_SPEEDS = 3'd6;
    localparam logic [2:0] CFG_MAN_SPEEDS  = 3'd7;

    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    typedef struct packed {
        logic [1:0]  operating_mode;
        logic [7:0]  recirc_start_bed_temp;
        logic [7:0]  hot_bed_threshold;
        logic [23:0] decision_ms;
        logic [2:0]  fan_present;
        logic [23:0] hot_speeds;
        logic [23:0] cold_speeds;
        logic [23:0] manual_speeds;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode_state;
        logic [31:0] timer_start;
        logic        timer_running;
        logic [7:0]  exhaust_hold;
        logic [7:0]  recirc_hold;
        logic [7:0]  heating_hold;
    } t_ctx;

    typedef struct packed {
        logic [31:0]       now_ms;
        logic signed [12:0] bed_temp_q4;
        logic              chamber_ok;
        logic [7:0]        pid_exhaust_speed;
    } t_tick;

endpackage

### rtl/fms_cfg.sv
// Configuration register file with the registered decision timer length.
module fms_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data,
    output fms_pkg::t_cfg       o_cfg
);

    logic [1:0]  r_mode;
    logic [7:0]  r_recirc_temp;
    logic [7:0]  r_hot_temp;
    logic [2:0]  r_fan_present;
    logic [23:0] r_hot_speeds;
    logic [23:0] r_cold_speeds;
    logic [23:0] r_man_speeds;
    logic [23:0] r_decision_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= fms_pkg::MODE_AUTO;
            r_recirc_temp <= 8'd0;
            r_hot_temp    <= 8'd0;
            r_fan_present <= 3'b111;
            r_hot_speeds  <= 24'd0;
            r_cold_speeds <= 24'd0;
            r_man_speeds  <= 24'd0;
            r_decision_ms <= 24'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fms_pkg::CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                    fms_pkg::CFG_RECIRC_TEMP: r_recirc_temp <= i_cfg_data[7:0];
                    fms_pkg::CFG_HOT_TEMP:    r_hot_temp    <= i_cfg_data[7:0];
                    // minutes * 60000 peaks at 15.3e6, fits 24 bits
                    fms_pkg::CFG_MINUTES:     r_decision_ms <= 24'(i_cfg_data[7:0]) *
                                                               24'(fms_pkg::MS_PER_MIN);
                    fms_pkg::CFG_FAN_PRESENT: r_fan_present <= i_cfg_data[2:0];
                    fms_pkg::CFG_HOT_SPEEDS:  r_hot_speeds  <= i_cfg_data;
                    fms_pkg::CFG_COLD_SPEEDS: r_cold_speeds <= i_cfg_data;
                    fms_pkg::CFG_MAN_SPEEDS:  r_man_speeds  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.operating_mode        = r_mode;
    assign o_cfg.recirc_start_bed_temp = r_recirc_temp;
    assign o_cfg.hot_bed_threshold     = r_hot_temp;
    assign o_cfg.decision_ms           = r_decision_ms;
    assign o_cfg.fan_present           = r_fan_present;
    assign o_cfg.hot_speeds            = r_hot_speeds;
    assign o_cfg.cold_speeds           = r_cold_speeds;
    assign o_cfg.manual_speeds         = r_man_speeds;

endmodule

### rtl/fms_step.sv
// Next-state and fan speed logic for one update tick.
module fms_step (
    input  fms_pkg::t_cfg  i_cfg,
    input  fms_pkg::t_ctx  i_ctx,
    input  fms_pkg::t_tick i_tick,
    output fms_pkg::t_ctx  o_ctx,
    output logic           o_pid_clear
);

    logic signed [13:0] w_bed;
    logic signed [13:0] w_recirc_thr;
    logic signed [13:0] w_hot_thr;
    logic               w_cold;
    logic               w_hot;
    logic               w_sensor_err;
    logic [31:0]        w_elapsed;
    logic               w_expired;
    logic [7:0]         w_heat_ex;
    logic [7:0]         w_heat_rc;
    logic [7:0]         w_heat_ht;
    logic [7:0]         w_cool_ex;
    logic [7:0]         w_cool_rc;

    assign w_bed        = 14'(i_tick.bed_temp_q4);
    assign w_recirc_thr = $signed({2'b00, i_cfg.recirc_start_bed_temp, 4'b0000});
    assign w_hot_thr    = $signed({2'b00, i_cfg.hot_bed_threshold, 4'b0000});
    assign w_cold       = w_bed < w_recirc_thr;
    assign w_hot        = w_bed >= w_hot_thr;
    assign w_sensor_err = !i_tick.chamber_ok;
    assign w_elapsed    = i_tick.now_ms - i_ctx.timer_start;
    assign w_expired    = i_ctx.timer_running && (w_elapsed >= {8'd0, i_cfg.decision_ms});

    // gated speed sets for heating and cooling
    assign w_heat_ex = i_cfg.fan_present[0] ? i_cfg.hot_speeds[7:0]   : 8'd0;
    assign w_heat_rc = i_cfg.fan_present[1] ? i_cfg.hot_speeds[15:8]  : 8'd0;
    assign w_heat_ht = i_cfg.fan_present[2] ? i_cfg.hot_speeds[23:16] : 8'd0;
    assign w_cool_ex = !i_cfg.fan_present[0] ? 8'd0 :
                       (w_sensor_err ? i_cfg.cold_speeds[15:8] : i_tick.pid_exhaust_speed);
    assign w_cool_rc = i_cfg.fan_present[1] ? i_cfg.cold_speeds[7:0] : 8'd0;

    always_comb begin
        fms_pkg::t_ctx st;
        logic          clr;
        logic          go_idle;
        logic          go_heat;
        logic          go_cool;
        logic          do_heat;
        logic          do_cool;
        st      = i_ctx;
        clr     = 1'b0;
        go_idle = 1'b0;
        go_heat = 1'b0;
        go_cool = 1'b0;
        do_heat = 1'b0;
        do_cool = 1'b0;

        if (i_cfg.operating_mode == fms_pkg::MODE_MANUAL) begin
            if (st.mode_state != fms_pkg::ST_MANUAL) begin
                st.mode_state    = fms_pkg::ST_MANUAL;
                st.timer_running = 1'b0;
                clr              = 1'b1;
            end
            st.exhaust_hold = i_cfg.manual_speeds[7:0];
            st.recirc_hold  = i_cfg.manual_speeds[15:8];
            st.heating_hold = i_cfg.manual_speeds[23:16];
        end else begin
            // leave manual through idle first
            if (st.mode_state == fms_pkg::ST_MANUAL) begin
                st.mode_state    = fms_pkg::ST_IDLE;
                st.timer_running = 1'b0;
                st.exhaust_hold  = 8'd0;
                st.recirc_hold   = 8'd0;
                st.heating_hold  = 8'd0;
                clr              = 1'b1;
            end
            if (w_sensor_err && st.mode_state == fms_pkg::ST_COOL && i_cfg.fan_present[0]) begin
                st.exhaust_hold = i_cfg.cold_speeds[15:8];
            end

            if (i_cfg.operating_mode == fms_pkg::MODE_HEAT) begin
                if (st.mode_state != fms_pkg::ST_HEAT) begin
                    go_heat = 1'b1;
                end else begin
                    do_heat = 1'b1;
                    if (w_expired) begin
                        st.timer_running = 1'b0;
                        go_idle          = w_cold;
                    end
                end
            end else if (i_cfg.operating_mode == fms_pkg::MODE_COOL) begin
                if (st.mode_state != fms_pkg::ST_COOL) begin
                    go_cool = 1'b1;
                end else begin
                    do_cool = 1'b1;
                    if (w_expired) begin
                        st.timer_running = 1'b0;
                        go_idle          = w_cold;
                    end
                end
            end else begin
                case (st.mode_state)
                    fms_pkg::ST_IDLE: begin
                        if (!w_cold) begin
                            st.mode_state    = fms_pkg::ST_RECIRC;
                            st.recirc_hold   = i_cfg.fan_present[1] ?
                                               i_cfg.cold_speeds[23:16] : 8'd0;
                            st.exhaust_hold  = 8'd0;
                            st.heating_hold  = 8'd0;
                            st.timer_start   = i_tick.now_ms;
                            st.timer_running = 1'b1;
                        end
                    end
                    fms_pkg::ST_RECIRC: begin
                        if (w_expired) begin
                            st.timer_running = 1'b0;
                            if (w_cold) begin
                                go_idle = 1'b1;
                            end else if (w_hot) begin
                                go_heat = 1'b1;
                            end else begin
                                go_cool = 1'b1;
                            end
                        end
                    end
                    fms_pkg::ST_HEAT: begin
                        do_heat = 1'b1;
                        go_idle = w_cold;
                    end
                    fms_pkg::ST_COOL: begin
                        do_cool = 1'b1;
                        go_idle = w_cold;
                    end
                    default: ;
                endcase
            end

            // hold the gated speed set of the current state
            if (do_heat) begin
                st.exhaust_hold = w_heat_ex;
                st.recirc_hold  = w_heat_rc;
                st.heating_hold = w_heat_ht;
            end
            if (do_cool) begin
                st.exhaust_hold = w_cool_ex;
                st.recirc_hold  = w_cool_rc;
                st.heating_hold = 8'd0;
            end
            if (go_heat || go_cool) begin
                clr = 1'b1;
                if (!st.timer_running) begin
                    st.timer_start   = i_tick.now_ms;
                    st.timer_running = 1'b1;
                end
                st.mode_state   = go_heat ? fms_pkg::ST_HEAT : fms_pkg::ST_COOL;
                st.exhaust_hold = go_heat ? w_heat_ex : w_cool_ex;
                st.recirc_hold  = go_heat ? w_heat_rc : w_cool_rc;
                st.heating_hold = go_heat ? w_heat_ht : 8'd0;
            end
            if (go_idle) begin
                st.mode_state    = fms_pkg::ST_IDLE;
                st.timer_running = 1'b0;
                st.exhaust_hold  = 8'd0;
                st.recirc_hold   = 8'd0;
                st.heating_hold  = 8'd0;
                clr              = 1'b1;
            end
        end

        o_ctx       = st;
        o_pid_clear = clr;
    end

endmodule

### rtl/enclosure_fan_mode_sequencer_core.sv
// Top level of the enclosure fan mode sequencer: request registers, state and result stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one update tick per request:
//   timestamp, bed temperature in sixteenths of a degree, chamber sensor flag and
//   the external PID exhaust speed. Output channel (o_out_valid / i_out_ready)
//   returns exactly one result per tick: three held fan speeds, the controller
//   state and the PID clear pulse.
//   Timing: an accepted request waits in the input register and moves on into the
//   result register when that register is free; its result is visible from there.
//   Throughput: one request per cycle while the receiver takes results; the
//   sequencer state updates in the same cycle the request moves into the result
//   register, so the next request already sees it.
//   Receiver stall: the result register holds; the input register still takes one
//   more request, then o_in_ready drops until the result is taken.
//   Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write a register at once;
//   the decision timer length (minutes * 60000) is computed at the write itself.
//   Reset (synchronous, active low): state idle, timer stopped, holds zero,
//   both stages empty, registers at their defaults.
module enclosure_fan_mode_sequencer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_now_ms,
    input  logic signed [12:0] i_bed_temp_q4,
    input  logic               i_chamber_ok,
    input  logic [7:0]         i_pid_exhaust_speed,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_exhaust_speed,
    output logic [7:0]         o_recirc_speed,
    output logic [7:0]         o_heating_speed,
    output logic [2:0]         o_ctrl_state_out,
    output logic               o_pid_clear
);

    fms_pkg::t_cfg  w_cfg;
    fms_pkg::t_tick r_in;
    logic           r_in_valid;
    fms_pkg::t_ctx  r_ctx;
    fms_pkg::t_ctx  n_ctx;
    logic           n_pid_clear;
    logic           r_out_valid;
    logic [7:0]     r_exhaust;
    logic [7:0]     r_recirc;
    logic [7:0]     r_heating;
    logic [2:0]     r_state_out;
    logic           r_pid_clear;
    logic           w_out_free;
    logic           w_move;

    fms_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    fms_step u_step (
        .i_cfg       (w_cfg),
        .i_ctx       (r_ctx),
        .i_tick      (r_in),
        .o_ctx       (n_ctx),
        .o_pid_clear (n_pid_clear)
    );

    // result register frees when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_move     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_move;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            // advance the sequencer only when the request moves on
            if (w_move) begin
                r_ctx <= n_ctx;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.now_ms            <= i_now_ms;
            r_in.bed_temp_q4       <= i_bed_temp_q4;
            r_in.chamber_ok        <= i_chamber_ok;
            r_in.pid_exhaust_speed <= i_pid_exhaust_speed;
        end
        if (w_move) begin
            r_exhaust   <= n_ctx.exhaust_hold;
            r_recirc    <= n_ctx.recirc_hold;
            r_heating   <= n_ctx.heating_hold;
            r_state_out <= n_ctx.mode_state;
            r_pid_clear <= n_pid_clear;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_exhaust_speed  = r_exhaust;
    assign o_recirc_speed   = r_recirc;
    assign o_heating_speed  = r_heating;
    assign o_ctrl_state_out = r_state_out;
    assign o_pid_clear      = r_pid_clear;

endmodule
